FILE: hdl/gap_buffer_text_engine_assert.svh
// Assertion macros used by the gap buffer text engine sequencer.
`ifndef GAP_BUFFER_TEXT_ENGINE_ASSERT_SVH
`define GAP_BUFFER_TEXT_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define GBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define GBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define GBT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GBT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/gbt_pkg.sv
// Package: constants, codes and state type of the gap buffer text engine.
`default_nettype none

package gbt_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int FIELD_W = 10;
   localparam int CHAR_W  = 8;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_MOVE   = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_MVRD,
      ST_MVWR,
      ST_DONE
   } gbt_state_type;

endpackage

`default_nettype wire

FILE: hdl/gbt_mem.sv
// Character store: single write port, single registered read port.
`default_nettype none

module gbt_mem #(
   parameter int DEPTH = gbt_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(gbt_pkg::CAPACITY_DEF)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [gbt_pkg::CHAR_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [gbt_pkg::CHAR_W-1:0] rd_data
);
   import gbt_pkg::*;

   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/gbt_seq.sv
// Sequencer: gap pointers, operation decode and the character copy loop.
`default_nettype none
`include "gap_buffer_text_engine_assert.svh"

module gbt_seq #(
   parameter int CAPACITY = gbt_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(gbt_pkg::CAPACITY_DEF)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [gbt_pkg::CHAR_W-1:0]  req_char_in,
   input  wire logic [gbt_pkg::FIELD_W-1:0] req_position,
   output logic                             rsp_valid,
   output logic      [1:0]                  rsp_status,
   output logic      [gbt_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic      [gbt_pkg::FIELD_W-1:0] rsp_cursor_pos,
   output logic      [gbt_pkg::FIELD_W-1:0] rsp_text_length,
   output logic                             mem_wr_en,
   output logic      [AW-1:0]               mem_wr_addr,
   output logic      [gbt_pkg::CHAR_W-1:0]  mem_wr_data,
   output logic                             mem_rd_en,
   output logic      [AW-1:0]               mem_rd_addr,
   input  wire logic [gbt_pkg::CHAR_W-1:0]  mem_rd_data
);
   import gbt_pkg::*;

   localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

   gbt_state_type state_ff, state_in;

   logic [1:0]         mode_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [FIELD_W-1:0] pos_ff;
   logic [AW-1:0]      gs_ff, gs_in;
   logic [AW-1:0]      gl_ff, gl_in;
   logic [1:0]         status_ff, status_in;
   logic [CHAR_W-1:0]  rdata_ff, rdata_in;

   logic [AW-1:0] diff;
   logic [AW-1:0] tl;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] tl_ext;
   logic [AW-1:0] pos_aw;
   logic          take;

   assign diff    = gl_ff - gs_ff;
   assign tl      = AW'(CAPACITY - 1) - diff;
   assign pos_ext = CW'(pos_ff);
   assign tl_ext  = CW'(tl);
   assign pos_aw  = pos_ext[AW-1:0];
   assign busy    = !((state_ff == ST_IDLE) || (state_ff == ST_DONE));
   assign take    = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (mode_ff)
               MODE_MOVE: state_in = (pos_ext > tl_ext) ? ST_DONE : ST_MVRD;
               MODE_READ: state_in = (pos_ext >= tl_ext) ? ST_DONE : ST_RDWAIT;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_RDWAIT: state_in = ST_DONE;
         ST_MVRD: begin
            state_in = (pos_aw == gs_ff) ? ST_DONE : ST_MVWR;
         end
         ST_MVWR: state_in = ST_MVRD;
         ST_DONE: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      gs_in       = gs_ff;
      gl_in       = gl_ff;
      status_in   = status_ff;
      rdata_in    = rdata_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = gs_ff;
      mem_wr_data = char_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = gs_ff;
      unique case (state_ff)
         ST_EXEC: begin
            status_in = STAT_OK;
            rdata_in  = '0;
            unique case (mode_ff)
               MODE_INSERT: begin
                  if (diff <= AW'(1)) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     gs_in     = gs_ff + AW'(1);
                  end
               end
               MODE_DELETE: begin
                  if (gs_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     gs_in = gs_ff - AW'(1);
                  end
               end
               MODE_MOVE: begin
                  if (pos_ext > tl_ext) status_in = STAT_RANGE;
               end
               default: begin
                  if (pos_ext >= tl_ext) begin
                     status_in = STAT_RANGE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = (pos_aw >= gs_ff) ? (pos_aw + diff + AW'(1)) : pos_aw;
                  end
               end
            endcase
         end
         ST_RDWAIT: begin
            rdata_in = mem_rd_data;
         end
         ST_MVRD: begin
            // fetch the character that crosses the gap
            if (pos_aw < gs_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = gs_ff - AW'(1);
            end else if (pos_aw > gs_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = gl_ff + AW'(1);
            end
         end
         ST_MVWR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            if (pos_aw < gs_ff) begin
               mem_wr_addr = gl_ff;
               gs_in       = gs_ff - AW'(1);
               gl_in       = gl_ff - AW'(1);
            end else begin
               mem_wr_addr = gs_ff;
               gs_in       = gs_ff + AW'(1);
               gl_in       = gl_ff + AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gs_ff    <= '0;
         gl_ff    <= AW'(CAPACITY - 1);
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         gl_ff    <= gl_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
      if (take) begin
         mode_ff <= req_mode;
         char_ff <= req_char_in;
         pos_ff  <= req_position;
      end
   end

   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_status      = status_ff;
   assign rsp_char_out    = rdata_ff;
   assign rsp_cursor_pos  = FIELD_W'(gs_ff);
   assign rsp_text_length = FIELD_W'(tl);

   `GBT_ASSERT_IMP(a_gap_kept, clock, reset, 1'b1, gl_ff > gs_ff)
   `GBT_ASSERT_IMP(a_full_real, clock, reset, rsp_valid && status_ff == STAT_FULL, diff <= AW'(1))
   `GBT_ASSERT_IMP(a_empty_real, clock, reset, rsp_valid && status_ff == STAT_EMPTY, gs_ff == '0)
   `GBT_ASSERT_IMP(a_char_on_read, clock, reset, rsp_valid && rdata_ff != '0, status_ff == STAT_OK && mode_ff == MODE_READ)
   `GBT_ASSERT_NXT(a_accept_busy, clock, reset, take, busy)

endmodule

`default_nettype wire

FILE: hdl/gap_buffer_text_engine.sv
// Top level of the gap buffer text engine: sequencer plus character store.
`default_nettype none

// Gap buffer text engine. Holds up to CAPACITY-2 characters in a store of
// CAPACITY bytes split by a gap whose start is the cursor. A request is taken
// when start is high and busy is low; every request yields exactly one
// response, shown for a single cycle with rsp_valid high, and the receiver
// cannot stall it, so sample the rsp_ ports whenever rsp_valid is high.
// Sequence after acceptance: insert, delete and any refused request pass
// through EXEC to DONE; a read passes through EXEC and RDWAIT (for the
// registered read port of the store) to DONE; a move passes through EXEC,
// then alternates MVRD and MVWR, since each character that crosses the gap
// is read in MVRD and written in MVWR through the single store port pair,
// and a last MVRD confirms that the cursor sits at the target.
// busy drops in the response cycle, so the next request may be
// accepted while the current response is shown. The store needs no clearing
// after reset; only slots that hold text are ever read. cursor_pos and
// text_length are reported modulo 1024.
module gap_buffer_text_engine #(
   parameter int CAPACITY = gbt_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [gbt_pkg::CHAR_W-1:0]  req_char_in,
   input  wire logic [gbt_pkg::FIELD_W-1:0] req_position,
   output logic                             rsp_valid,
   output logic      [1:0]                  rsp_status,
   output logic      [gbt_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic      [gbt_pkg::FIELD_W-1:0] rsp_cursor_pos,
   output logic      [gbt_pkg::FIELD_W-1:0] rsp_text_length
);
   import gbt_pkg::*;

   // store address width
   localparam int AW = $clog2(CAPACITY);

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   // sequencer: decode, gap pointers, copy loop for moves
   gbt_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_char_in     (req_char_in),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_text_length (rsp_text_length),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // character store
   gbt_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: tb/gap_buffer_text_engine_checker.sv
// Response checker for the gap buffer text engine: predicts every response and compares it.
`timescale 1ns / 100ps

module gap_buffer_text_engine_checker #(
   parameter int CAPACITY = gbt_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [gbt_pkg::CHAR_W-1:0]  req_char_in,
   input  wire logic [gbt_pkg::FIELD_W-1:0] req_position,
   input  wire logic                        rsp_valid,
   input  wire logic [1:0]                  rsp_status,
   input  wire logic [gbt_pkg::CHAR_W-1:0]  rsp_char_out,
   input  wire logic [gbt_pkg::FIELD_W-1:0] rsp_cursor_pos,
   input  wire logic [gbt_pkg::FIELD_W-1:0] rsp_text_length,
   output int                               fail_count,
   output int                               pending_count
);
   import gbt_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [CHAR_W-1:0]  char_out;
      logic [FIELD_W-1:0] cursor_pos;
      logic [FIELD_W-1:0] text_length;
   } text_result_type;

   logic [CHAR_W-1:0] text_store [CAPACITY];
   int unsigned       gap_lo;
   int unsigned       gap_hi;
   text_result_type   awaited_rsp [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic int unsigned chars_held();
      return CAPACITY - 1 - (gap_hi - gap_lo);
   endfunction

   // Slide the gap one character at a time until its start sits at target.
   function automatic void slide_gap(input int unsigned target);
      while (target < gap_lo) begin
         gap_lo--;
         text_store[gap_hi] = text_store[gap_lo];
         gap_hi--;
      end
      while (target > gap_lo) begin
         gap_hi++;
         text_store[gap_lo] = text_store[gap_hi];
         gap_lo++;
      end
   endfunction

   function automatic text_result_type run_text_op(input logic [1:0] mode,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [FIELD_W-1:0] pos);
      text_result_type res;
      int unsigned     len;
      int unsigned     slot;
      len          = chars_held();
      res.status   = STAT_OK;
      res.char_out = '0;
      case (mode)
         MODE_INSERT: begin
            if (gap_hi - gap_lo <= 1) begin
               res.status = STAT_FULL;
            end else begin
               text_store[gap_lo] = ch;
               gap_lo++;
            end
         end
         MODE_DELETE: begin
            if (gap_lo == 0) res.status = STAT_EMPTY;
            else gap_lo--;
         end
         MODE_MOVE: begin
            if (pos > len) res.status = STAT_RANGE;
            else slide_gap(pos);
         end
         default: begin
            if (pos >= len) begin
               res.status = STAT_RANGE;
            end else begin
               slot = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo) + 1;
               res.char_out = text_store[slot];
            end
         end
      endcase
      len             = chars_held();
      res.cursor_pos  = gap_lo[FIELD_W-1:0];
      res.text_length = len[FIELD_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      fail_count++;
      if (fail_count <= 30)
         $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      text_result_type want;
      if (reset) begin
         gap_lo = 0;
         gap_hi = CAPACITY - 1;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("response with no request outstanding", 16'(0), 16'(0));
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 16'(rsp_status), 16'(want.status));
               if (rsp_char_out !== want.char_out)
                  report_mismatch("char_out", 16'(rsp_char_out), 16'(want.char_out));
               if (rsp_cursor_pos !== want.cursor_pos)
                  report_mismatch("cursor_pos", 16'(rsp_cursor_pos),
                                  16'(want.cursor_pos));
               if (rsp_text_length !== want.text_length)
                  report_mismatch("text_length", 16'(rsp_text_length),
                                  16'(want.text_length));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            awaited_rsp.push_back(run_text_op(req_mode, req_char_in, req_position));
      end
      pending_count <= awaited_rsp.size();
   end

endmodule

FILE: tb/gap_buffer_text_engine_test.sv
// Testbench top for the gap buffer text engine: request stimulus, checker hookup and verdict.
`timescale 1ns / 100ps

module gap_buffer_text_engine_test;
   import gbt_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_mode = MODE_READ;
   logic [CHAR_W-1:0]  req_char_in = '0;
   logic [FIELD_W-1:0] req_position = '0;
   logic               busy;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [CHAR_W-1:0]  rsp_char_out;
   logic [FIELD_W-1:0] rsp_cursor_pos;
   logic [FIELD_W-1:0] rsp_text_length;

   int fail_count;
   int pending_count;

   // Stimulus bookkeeping: text length last reported and tallies for the
   // closing summary.
   int unsigned last_len = 0;
   int unsigned peak_len = 0;
   int          mode_count [4] = '{0, 0, 0, 0};
   int          status_seen [4] = '{0, 0, 0, 0};
   bit          steady_run = 1'b0;

   gap_buffer_text_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_char_in     (req_char_in),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_text_length (rsp_text_length)
   );

   gap_buffer_text_engine_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_char_in     (req_char_in),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_text_length (rsp_text_length),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Track what the block reports so positions can be aimed at the live text.
   // Nonblocking updates keep the stimulus process reading last cycle's value.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         last_len <= 32'(rsp_text_length);
         if (32'(rsp_text_length) > peak_len) peak_len <= 32'(rsp_text_length);
         status_seen[rsp_status] <= status_seen[rsp_status] + 1;
      end
   end

   // Pick an idle gap before the next request: mostly none, sometimes a few
   // cycles, now and then a long one. Steady runs drop idling altogether.
   function automatic int pick_gap();
      int roll;
      if (steady_run) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Aim most positions inside the text, some exactly at its end (legal for a
   // move, out of range for a read), the rest anywhere in the field.
   function automatic logic [FIELD_W-1:0] pick_position(input bit for_read);
      int unsigned roll;
      int unsigned top_pos;
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
         if (for_read) top_pos = (last_len == 0) ? 0 : last_len - 1;
         else top_pos = last_len;
         return FIELD_W'($urandom_range(0, top_pos));
      end
      if (roll < 85) return FIELD_W'(last_len);
      return FIELD_W'($urandom_range(0, 1023));
   endfunction

   // Present one request and hold it until the block takes it. start is only
   // lowered when an idle gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic [1:0] mode, input logic [CHAR_W-1:0] ch,
                               input logic [FIELD_W-1:0] pos);
      int idle;
      idle = pick_gap();
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_char_in  <= ch;
      req_position <= pos;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      mode_count[mode]++;
   endtask

   // Random mix of operations; the read share is whatever the weights leave.
   // Fields an operation ignores still carry random values.
   task automatic random_requests(input int count, input int w_ins, input int w_del,
                                  input int w_mov);
      int n;
      int roll;
      logic [CHAR_W-1:0]  ch;
      logic [FIELD_W-1:0] pos;
      for (n = 0; n < count; n++) begin
         if (n % 32 == 0) steady_run = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         ch   = CHAR_W'($urandom_range(0, 255));
         pos  = FIELD_W'($urandom_range(0, 1023));
         if (roll < w_ins) send_request(MODE_INSERT, ch, pos);
         else if (roll < w_ins + w_del) send_request(MODE_DELETE, ch, pos);
         else if (roll < w_ins + w_del + w_mov) send_request(MODE_MOVE, ch, pick_position(1'b0));
         else send_request(MODE_READ, ch, pick_position(1'b1));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening on an empty store: delete at the start, a read and
      // moves out of range, the legal move to zero.
      send_request(MODE_DELETE, 8'h3C, 10'd0);
      send_request(MODE_READ,   8'h00, 10'd0);
      send_request(MODE_MOVE,   8'h00, 10'd0);
      send_request(MODE_MOVE,   8'h00, 10'd1);
      send_request(MODE_MOVE,   8'hFF, 10'd1023);
      // Character extremes, then read them back and overrun the end.
      send_request(MODE_INSERT, 8'h00, 10'd1023);
      send_request(MODE_INSERT, 8'hFF, 10'd0);
      send_request(MODE_INSERT, 8'h80, 10'd0);
      send_request(MODE_INSERT, 8'h01, 10'd0);
      send_request(MODE_READ,   8'h00, 10'd0);
      send_request(MODE_READ,   8'h00, 10'd1);
      send_request(MODE_READ,   8'h00, 10'd2);
      send_request(MODE_READ,   8'h00, 10'd3);
      send_request(MODE_READ,   8'h00, 10'd4);
      // Move back into the text, insert there and read across the gap.
      send_request(MODE_MOVE,   8'h00, 10'd2);
      send_request(MODE_INSERT, 8'h7F, 10'd0);
      send_request(MODE_READ,   8'h00, 10'd3);
      // Move to the very end, one past it, and to the current cursor.
      send_request(MODE_MOVE,   8'h00, 10'd5);
      send_request(MODE_MOVE,   8'h00, 10'd6);
      send_request(MODE_MOVE,   8'h00, 10'd5);
      send_request(MODE_DELETE, 8'h00, 10'd0);
      // Delete at the start while text remains after the cursor.
      send_request(MODE_MOVE,   8'h00, 10'd0);
      send_request(MODE_DELETE, 8'h00, 10'd0);
      send_request(MODE_READ,   8'h00, 10'd1023);
      send_request(MODE_MOVE,   8'h00, 10'd4);

      // Random phases: grow the text, churn it, drain it.
      random_requests(180, 45, 15, 15);
      random_requests(120, 20, 20, 25);
      random_requests(126, 10, 60, 10);

      // Drop start, wait out every outstanding response, then idle a while
      // so a stray response would still be caught.
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("requests: %0d insert, %0d delete, %0d move, %0d read; peak text length %0d",
               mode_count[MODE_INSERT], mode_count[MODE_DELETE], mode_count[MODE_MOVE],
               mode_count[MODE_READ], peak_len);
      $display("responses: %0d ok, %0d nothing to delete, %0d full, %0d out of range",
               status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
               status_seen[STAT_RANGE]);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run: long moves across the
   // text, long idle gaps and roughly four hundred fifty requests.
   initial begin
      #20_000_000;
      $display("timeout: responses stopped arriving");
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: gap_buffer_text_engine.f
+incdir+hdl
hdl/gbt_pkg.sv
hdl/gbt_mem.sv
hdl/gbt_seq.sv
hdl/gap_buffer_text_engine.sv
tb/gap_buffer_text_engine_checker.sv
tb/gap_buffer_text_engine_test.sv
